// ===== sv/ecs_pkg.sv =====
// Shared types and codes for the exponential conductance synapse.
// No dependencies; imported by ecs_ctrl, ecs_dp and exp_conductance_synapse.
package ecs_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_REV    = 3'd1;
  localparam logic [2:0] REG_DECAY  = 3'd2;
  localparam logic [2:0] REG_DELAY  = 3'd3;
  localparam logic [2:0] REG_WEIGHT = 3'd4;

  localparam logic [15:0] WEIGHT_RESET = 16'd4096;  // 1.0 in Q4.12
  localparam logic [23:0] G_MAX        = 24'hFFFFFF;
  localparam logic [24:0] G_ONE        = 25'h0010000;

  typedef struct packed {
    logic        mode;
    logic [15:0] rev;     // signed Q8.8
    logic [15:0] decay;   // unsigned Q0.16
    logic [15:0] delay;
    logic [15:0] weight;  // signed Q4.12
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic update;
    logic mul1;
    logic mul2;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ===== sv/exp_conductance_synapse.sv =====
// Top level of the exponential conductance synapse: ports, configuration
// registers, and the ecs_ctrl / ecs_dp pair. Depends on ecs_pkg.
//
//  channel  ports                                payload
//  -------  -----------------------------------  ---------------------------
//  input    in_tvalid  in_tready  in_tdata[47:0]  time_stamp, membrane_potential
//                      in_tuser[1:0]             cmd
//  result   out_tvalid out_tready out_tdata[63:0] syn_current, conductance_out,
//                      out_tuser[1:0]            pending_spikes; status
//  config   cfg_valid  cfg_ready  cfg_index[2:0]  register write, cfg_data[15:0]
//
// Each item goes through these steps from its transfer to the earliest next transfer:
// capture, queue and conductance update (one registered queue read plus the
// decay multiply), weight multiply, reversal-potential multiply, result load.
// The next item is taken while a loaded result still waits on out_tready.
// If the result register is still occupied, the block holds in its last step.
// rst_n (synchronous, active low) clears control, conductance, queue pointers
// and configuration; queue contents are left as they are.
module exp_conductance_synapse #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] time_stamp, [47:32] membrane_potential
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] syn_current, [55:32] conductance_out,
                                  // [60:56] pending_spikes, [63:61] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ecs_pkg::*;

  cfg_t       cfg_r;
  ctrl_cmd_t  cmd;
  logic [31:0] res_current;
  logic [23:0] res_g;
  logic [4:0]  res_pending;
  logic [1:0]  res_status;

  // Writes must arrive only while idle, a duty of the user that the block does not enforce; it always takes them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= 1'b0;
      cfg_r.rev    <= '0;
      cfg_r.decay  <= '0;
      cfg_r.delay  <= '0;
      cfg_r.weight <= WEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   cfg_r.mode   <= cfg_data[0];
        REG_REV:    cfg_r.rev    <= cfg_data;
        REG_DECAY:  cfg_r.decay  <= cfg_data;
        REG_DELAY:  cfg_r.delay  <= cfg_data;
        REG_WEIGHT: cfg_r.weight <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  ecs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ecs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd         (cmd),
    .in_cmd      (in_tuser),
    .in_time     (in_tdata[31:0]),
    .in_pot      (in_tdata[47:32]),
    .res_status  (res_status),
    .res_current (res_current),
    .res_g       (res_g),
    .res_pending (res_pending)
  );

  assign out_tdata = {3'b000, res_pending, res_g, res_current};
  assign out_tuser = res_status;

endmodule

// ===== sv/ecs_ctrl.sv =====
// Sequencer for the synapse: capture, update, two multiplies, output load.
// Depends on ecs_pkg for the command struct.
module ecs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ecs_pkg::ctrl_cmd_t cmd
);
  import ecs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.load_in  = 1'b0;
    cmd.update   = 1'b0;
    cmd.mul1     = 1'b0;
    cmd.mul2     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_UPD))
    else $error("accepted item did not enter update");

  a_mul2_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2) |=> (state_r == S_DONE))
    else $error("sequence skipped done state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

// ===== sv/ecs_dp.sv =====
// Datapath: arrival queue memory, conductance register, current multipliers
// and result register. Depends on ecs_pkg; driven by ecs_ctrl commands.
module ecs_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ecs_pkg::cfg_t      cfg,
  input  ecs_pkg::ctrl_cmd_t cmd,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_time,
  input  logic [15:0]        in_pot,
  output logic [1:0]         res_status,
  output logic [31:0]        res_current,
  output logic [23:0]        res_g,
  output logic [4:0]         res_pending
);
  import ecs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [31:0] mem [QUEUE_DEPTH];
  logic [31:0] head_r;

  logic [1:0]  cmd_r;
  logic [31:0] ts_r;        // arrival time for add, step time for tick
  logic signed [16:0] diff_r;

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   newest_r;
  logic [23:0]   g_r, g_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          wr_en;

  logic [24:0]   g_inc;
  logic [39:0]   g_dec;
  logic signed [39:0] wg_r;
  logic signed [39:0] wg_full;
  logic signed [56:0] prod_r;
  logic signed [36:0] prod_sh;
  logic [31:0]   cur;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= in_cmd;
      ts_r   <= (in_cmd == CMD_ADD) ? in_time + {16'd0, cfg.delay} : in_time;
      diff_r <= $signed({cfg.rev[15], cfg.rev}) - $signed({in_pot[15], in_pot});
    end
  end

  // queue memory, registered head read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= ts_r;
    head_r <= mem[rd_ptr_r];
  end

  assign g_inc = {1'b0, g_r} + G_ONE;
  assign g_dec = {16'd0, g_r} * {24'd0, cfg.decay};

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    g_nxt      = g_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    if (cmd.update) begin
      case (cmd_r)
        CMD_ADD: begin
          if (cnt_r != '0 && newest_r >= ts_r) begin
            status_nxt = ST_ORDER;
          end else if (cnt_r == CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_ptr_nxt = ptr_inc(wr_ptr_r);
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
        CMD_TICK: begin
          if (cnt_r != '0 && head_r == ts_r) begin
            g_nxt      = g_inc[24] ? G_MAX : g_inc[23:0];
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            cnt_nxt    = cnt_r - 1'b1;
          end else if (g_r <= 24'd1) begin
            g_nxt = '0;
          end else begin
            g_nxt = g_dec[39:16];
          end
        end
        CMD_CLEAR: begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          cnt_nxt    = '0;
          g_nxt      = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
      g_r      <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      g_r      <= g_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) newest_r <= ts_r;
    if (cmd.update) status_r <= status_nxt;
  end

  // current: w*g, then w*g*(E-u); w*g always fits in 40 signed bits
  assign wg_full = 40'($signed(cfg.weight)) * 40'($signed({1'b0, g_r}));

  always_ff @(posedge clk) begin
    if (cmd.mul1) wg_r <= wg_full;
    if (cmd.mul2) prod_r <= 57'(wg_r) * 57'(diff_r);
  end

  assign prod_sh = prod_r[56:20];

  always_comb begin
    if (!cfg.mode) begin
      cur = {{4{wg_r[39]}}, wg_r[39:12]};
    end else if (prod_sh[36:31] == {6{prod_sh[31]}}) begin
      cur = prod_sh[31:0];
    end else if (prod_sh[36]) begin
      cur = 32'h80000000;
    end else begin
      cur = 32'h7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_status  <= status_r;
      res_current <= cur;
      res_g       <= g_r;
      res_pending <= 5'(cnt_r);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r != CNT_FULL))
    else $error("write into full queue");

  a_ptr_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with split pointers");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for exp_conductance_synapse: directed and random command streams
// are predicted in the bench and compared transfer by transfer. Depends on ecs_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;  // no named code; block must leave state alone
  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;  // comfortably above the time one item takes
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP = 40;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        stamp;
    logic signed [15:0] vmem;
  } syn_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] current;
    logic [23:0]        g;
    logic [4:0]         pending;
  } syn_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [31:0] time_stamp, [47:32] membrane_potential
  logic [1:0]  in_tuser = '0;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] syn_current, [55:32] conductance, [60:56] pending
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic hold_rx = 1'b0;  // long receiver hold-off, owned by the pressure test
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // Bench copy of the synapse: registers, arrival queue, conductance.
  cfg_t        cfg_m;
  logic [31:0] arrivals_m [DEPTH];
  logic [23:0] g_m;
  int          rd_m, wr_m, cnt_m;
  syn_result_t results_due [$];

  exp_conductance_synapse #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Current from a conductance: w*g in mode 0, w*g*(E-u) in mode 1, floored and
  // clamped to the signed 32-bit range.
  function automatic logic [31:0] synapse_current(logic [23:0] g, logic signed [15:0] vmem);
    longint w, gl, drive, acc;
    w = 64'($signed(cfg_m.weight));
    gl = 64'(g);
    drive = 64'($signed(cfg_m.rev));
    drive = drive - 64'(vmem);
    if (cfg_m.mode == 1'b0) acc = (w * gl) >>> 12;
    else acc = (w * gl * drive) >>> 20;
    if (acc > I32_MAX) return 32'h7FFF_FFFF;
    if (acc < I32_MIN) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  // Apply one command to the bench copy and return the result it must produce.
  function automatic syn_result_t advance_synapse(syn_item_t it);
    syn_result_t r;
    logic [31:0] arrival;
    logic [24:0] raised;
    logic [39:0] decayed;
    r.status = ST_OK;
    case (it.cmd)
      CMD_ADD: begin
        arrival = it.stamp + {16'd0, cfg_m.delay};
        // ordering is checked against the newest arrival and wins over a full queue
        if (cnt_m > 0 && arrivals_m[(wr_m + DEPTH - 1) % DEPTH] >= arrival) begin
          r.status = ST_ORDER;
        end else if (cnt_m >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          arrivals_m[wr_m] = arrival;
          wr_m = (wr_m + 1) % DEPTH;
          cnt_m++;
        end
      end
      CMD_TICK: begin
        if (cnt_m > 0 && arrivals_m[rd_m] == it.stamp) begin
          raised = {1'b0, g_m} + G_ONE;
          g_m = (raised > {1'b0, G_MAX}) ? G_MAX : raised[23:0];
          rd_m = (rd_m + 1) % DEPTH;
          cnt_m--;
        end else if (g_m <= 24'd1) begin
          g_m = '0;
        end else begin
          decayed = 40'(g_m) * 40'(cfg_m.decay);
          g_m = decayed[39:16];
        end
      end
      CMD_CLEAR: begin
        rd_m = 0;
        wr_m = 0;
        cnt_m = 0;
        g_m = '0;
      end
      default: ;
    endcase
    r.current = synapse_current(g_m, it.vmem);
    r.g = g_m;
    r.pending = 5'(cnt_m);
    return r;
  endfunction

  // Random command biased toward sequences that get past the queue checks:
  // adds just after the newest arrival, ticks on the oldest one.
  function automatic syn_item_t pick_item();
    syn_item_t it;
    logic [31:0] newest, head;
    int sel;
    sel = $urandom_range(99);
    newest = arrivals_m[(wr_m + DEPTH - 1) % DEPTH];
    head = arrivals_m[rd_m];
    it.cmd = CMD_TICK;
    it.stamp = $urandom;
    it.vmem = 16'($urandom);
    if (sel < 40) begin
      it.cmd = CMD_ADD;
      if (cnt_m == 0) begin
        if ($urandom_range(1) == 0) it.stamp = $urandom_range(2000);
      end else if ($urandom_range(9) == 0) begin
        it.stamp = newest - 32'(cfg_m.delay) - $urandom_range(2);
      end else begin
        it.stamp = newest - 32'(cfg_m.delay) + $urandom_range(4, 1);
      end
    end else if (sel < 85) begin
      if (cnt_m > 0) begin
        case ($urandom_range(5))
          0: it.stamp = head - 1;
          1: it.stamp = head + 1;
          2: ;
          default: it.stamp = head;
        endcase
      end
    end else if (sel < 90) begin
      it.cmd = CMD_CLEAR;
    end else if (sel < 94) begin
      it.cmd = CMD_UNUSED;
    end else begin
      it.cmd = 2'($urandom_range(3));
    end
    return it;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t: %s mismatch, got %h want %h", $time, field, got, want);
    fail_count++;
  endtask

  // Offer one item, wait for its transfer, then log its prediction.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] stamp,
                           input logic [15:0] vmem);
    syn_item_t it;
    it.cmd = cmd;
    it.stamp = stamp;
    it.vmem = vmem;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vmem, stamp};
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    results_due.push_back(advance_synapse(it));
  endtask

  // Drop valid and hold until every predicted result has been seen, then let
  // the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:   cfg_m.mode = value[0];
      REG_REV:    cfg_m.rev = value;
      REG_DECAY:  cfg_m.decay = value;
      REG_DELAY:  cfg_m.delay = value;
      REG_WEIGHT: cfg_m.weight = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register, only once the block has gone quiet.
  task automatic set_config(input logic mode, input logic [15:0] rev, input logic [15:0] decay,
                            input logic [15:0] delay, input logic [15:0] weight);
    wait_idle();
    write_reg(REG_MODE, {15'd0, mode});
    write_reg(REG_REV, rev);
    write_reg(REG_DECAY, decay);
    write_reg(REG_DELAY, delay);
    write_reg(REG_WEIGHT, weight);
  endtask

  task automatic run_random(input int n);
    syn_item_t it;
    repeat (n) begin
      it = pick_item();
      send_item(it.cmd, it.stamp, it.vmem);
    end
  endtask

  // Queue ordering, hits, misses, decay of one LSB to zero, unused code, clear.
  task automatic test_spike_order();
    set_config(1'b0, 16'h0000, 16'h0001, 16'h0003, WEIGHT_RESET);
    send_item(CMD_TICK, 32'd0, 16'h0100);   // empty queue: decay only
    send_item(CMD_ADD, 32'd10, 16'h0100);   // arrival 13
    send_item(CMD_ADD, 32'd10, 16'h0100);   // equal to newest: rejected
    send_item(CMD_ADD, 32'd4, 16'h0100);    // earlier than newest: rejected
    send_item(CMD_ADD, 32'd20, 16'h0100);   // arrival 23
    send_item(CMD_TICK, 32'd12, 16'hFF00);  // miss
    send_item(CMD_TICK, 32'd13, 16'hFF00);  // hit, g = 1.0
    send_item(CMD_TICK, 32'd14, 16'h0000);  // decay to one LSB
    send_item(CMD_TICK, 32'd15, 16'h0000);  // one LSB snaps to zero
    send_item(CMD_TICK, 32'd23, 16'h0000);  // hit on the second arrival
    send_item(CMD_UNUSED, 32'd23, 16'h1234);
    send_item(CMD_CLEAR, 32'd0, 16'h0000);
  endtask

  // Fill the queue, overflow it, and check that ordering wins over full.
  task automatic test_queue_limits();
    set_config(1'b0, 16'h0000, 16'h8000, 16'hFFFF, WEIGHT_RESET);
    send_item(CMD_CLEAR, 32'd0, 16'h0000);
    for (int i = 0; i < DEPTH; i++) send_item(CMD_ADD, i, 16'h0000);
    send_item(CMD_ADD, DEPTH, 16'h0000);    // full
    send_item(CMD_ADD, 32'd3, 16'h0000);    // out of order and full: order reported
    send_item(CMD_TICK, 32'd65535, 16'h0000);
  endtask

  // Field extremes, arrival wrap past 2^32, both current modes at the limits.
  task automatic test_mode_extremes();
    set_config(1'b1, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 16'h7FFF);
    send_item(CMD_ADD, 32'hFFFF_0000, 16'h7FFF);  // arrival is all ones
    send_item(CMD_ADD, 32'hFFFF_0001, 16'h8000);  // wraps to zero: out of order
    send_item(CMD_TICK, 32'hFFFF_FFFF, 16'h7FFF);
    send_item(CMD_TICK, 32'h0000_0000, 16'h8000);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'h0000);
    set_config(1'b0, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
    send_item(CMD_UNUSED, 32'h0000_0000, 16'h7FFF);
    send_item(CMD_TICK, 32'h5555_AAAA, 16'h8000);  // zero decay factor
  endtask

  task automatic test_random_traffic(input int settings, input int per_setting);
    logic [15:0] decay, delay;
    repeat (settings) begin
      case ($urandom_range(3))
        0: decay = 16'hFFFF;
        1: decay = 16'hFFFF - 16'($urandom_range(4095));
        default: decay = 16'($urandom);
      endcase
      delay = ($urandom_range(1) == 0) ? 16'($urandom_range(8)) : 16'($urandom);
      set_config(1'($urandom), 16'($urandom), decay, delay, 16'($urandom));
      run_random(per_setting);
    end
  endtask

  // Stall the receiver long enough for the block to back up into its input,
  // keep offering items, then pause the sender until everything has drained.
  task automatic test_backpressure();
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    run_random(40);
    wait_idle();
  endtask

  // Hit after hit until the conductance pins at its ceiling; mode 1 with full
  // weight drives the current into both clamps.
  task automatic test_conductance_ceiling();
    logic [31:0] stamp;
    stamp = 32'h0000_1000;
    set_config(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF);
    send_item(CMD_CLEAR, 32'd0, 16'h0000);
    repeat (130) begin
      send_item(CMD_ADD, stamp, 16'($urandom));
      send_item(CMD_TICK, stamp, 16'($urandom));
      stamp++;
    end
    set_config(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000);
    repeat (130) begin
      send_item(CMD_ADD, stamp, 16'($urandom));
      send_item(CMD_TICK, stamp, 16'($urandom));
      stamp++;
    end
    send_item(CMD_TICK, stamp, 16'($urandom));  // decay from the ceiling
    send_item(CMD_TICK, stamp, 16'($urandom));
  endtask

  // Receiver: random stalls, or a solid hold-off while hold_rx is up.
  always @(posedge clk) out_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    syn_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[31:0] !== want.current)
          report_mismatch("syn_current", out_tdata[31:0], want.current);
        if (out_tdata[55:32] !== want.g)
          report_mismatch("conductance_out", 32'(out_tdata[55:32]), 32'(want.g));
        if (out_tdata[60:56] !== want.pending)
          report_mismatch("pending_spikes", 32'(out_tdata[60:56]), 32'(want.pending));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles", cycle_count);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    // bench copy starts from the reset state
    cfg_m = '{mode: 1'b0, rev: 16'd0, decay: 16'd0, delay: 16'd0, weight: WEIGHT_RESET};
    g_m = '0;
    rd_m = 0;
    wr_m = 0;
    cnt_m = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalling
    tx_idle_pct = 16;
    rx_idle_pct = 70;
    test_spike_order();
    test_queue_limits();
    test_mode_extremes();
    test_random_traffic(3, 20);

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 70;
    rx_idle_pct = 16;
    test_random_traffic(3, 20);
    test_backpressure();

    // back to back on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(3, 20);
    test_conductance_ceiling();

    wait_idle();
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
